@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion; the enclosing module provides clk_i and rst_ni.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the clock cycle after the trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (trig) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/qhpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadrature/hall position tracker package
// Widths, event codes, transfer payload types and the hall sector map.
// ----------------------------------------------------------------------------
package qhpt_pkg;

  localparam int ANGLE_BITS  = 32;
  localparam int FINE_BITS   = 16;
  localparam int OUT_BITS    = 32;
  localparam int COUNT_BITS  = 10;
  localparam int SECTOR_BITS = 3;
  localparam int HALL_BITS   = 3;
  localparam int KIND_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] SECTOR_COUNTS_RESET = COUNT_BITS'(78);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_A    = 2'd0,
    KIND_B    = 2'd1,
    KIND_HALL = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 rising;
    logic                 other_level;
    logic [HALL_BITS-1:0] hall_bits;
  } event_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]         coarse;
    logic signed [FINE_BITS-1:0] fine;
    logic [SECTOR_BITS-1:0]      sector;
  } result_t;

  // Hall code (I3 I2 I1) to sector; the two impossible codes land on sector 0.
  function automatic logic [SECTOR_BITS-1:0] hall_to_sector(logic [HALL_BITS-1:0] bits);
    logic [SECTOR_BITS-1:0] s;
    case (bits)
      3'd5:    s = 3'd0;
      3'd4:    s = 3'd1;
      3'd6:    s = 3'd2;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd4;
      3'd1:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/qhpt_core.sv @@
// ----------------------------------------------------------------------------
// Position tracker core
// Holds fine count, coarse angle and sector, and updates them per event.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qhpt_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  qhpt_pkg::event_t                     ev_i,
  input  logic [qhpt_pkg::COUNT_BITS-1:0]      sector_counts_i,
  output qhpt_pkg::result_t                    res_o
);

  localparam logic signed [qhpt_pkg::FINE_BITS-1:0] FineMax =
    {1'b0, {(qhpt_pkg::FINE_BITS-1){1'b1}}};
  localparam logic signed [qhpt_pkg::FINE_BITS-1:0] FineMin =
    {1'b1, {(qhpt_pkg::FINE_BITS-1){1'b0}}};

  logic signed [qhpt_pkg::FINE_BITS-1:0]  fine_q, fine_d;
  logic signed [qhpt_pkg::ANGLE_BITS-1:0] coarse_q, coarse_d;
  logic [qhpt_pkg::SECTOR_BITS-1:0]       sector_q, sector_d;
  logic                                   awaiting_q, awaiting_d;

  logic [qhpt_pkg::SECTOR_BITS-1:0] sector_new;
  logic signed [3:0]                diff_raw, diff;
  logic signed [14:0]               sector_step;
  logic                             count_up;

  assign sector_new = qhpt_pkg::hall_to_sector(ev_i.hall_bits);
  assign diff_raw   = signed'({1'b0, sector_new}) - signed'({1'b0, sector_q});

  // A jump of five sectors is really one step the other way around the circle.
  always_comb begin
    if (diff_raw == 4'sd5) begin
      diff = -4'sd1;
    end else if (diff_raw == -4'sd5) begin
      diff = 4'sd1;
    end else begin
      diff = diff_raw;
    end
  end

  assign sector_step = 15'(diff) * 15'(signed'({1'b0, sector_counts_i}));

  // Channel A counts up when its edge disagrees with B; channel B when it agrees.
  assign count_up = (ev_i.kind == qhpt_pkg::KIND_A) ? (ev_i.rising != ev_i.other_level)
                                                   : (ev_i.rising == ev_i.other_level);

  always_comb begin
    fine_d     = fine_q;
    coarse_d   = coarse_q;
    sector_d   = sector_q;
    awaiting_d = awaiting_q;
    if (step_i) begin
      case (qhpt_pkg::kind_e'(ev_i.kind))
        qhpt_pkg::KIND_A, qhpt_pkg::KIND_B: begin
          if (count_up) begin
            if (fine_q != FineMax) fine_d = fine_q + qhpt_pkg::FINE_BITS'(1);
          end else begin
            if (fine_q != FineMin) fine_d = fine_q - qhpt_pkg::FINE_BITS'(1);
          end
        end
        qhpt_pkg::KIND_HALL: begin
          if (awaiting_q) begin
            coarse_d = qhpt_pkg::ANGLE_BITS'(fine_q);
          end else begin
            coarse_d = coarse_q + qhpt_pkg::ANGLE_BITS'(sector_step);
          end
          sector_d   = sector_new;
          fine_d     = '0;
          awaiting_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_q     <= '0;
      coarse_q   <= '0;
      sector_q   <= '0;
      awaiting_q <= 1'b1;
    end else begin
      fine_q     <= fine_d;
      coarse_q   <= coarse_d;
      sector_q   <= sector_d;
      awaiting_q <= awaiting_d;
    end
  end

  assign res_o.coarse = qhpt_pkg::OUT_BITS'(coarse_d);
  assign res_o.fine   = fine_d;
  assign res_o.sector = sector_d;

  `ASSERT_NEXT(a_hall_clears_fine, step_i && (ev_i.kind == qhpt_pkg::KIND_HALL),
    (fine_q == '0) && !awaiting_q, "hall event did not clear fine count")
  `ASSERT_NEXT(a_first_stays_done, !awaiting_q, !awaiting_q,
    "first-edge flag came back")
  `ASSERT_NEXT(a_idle_holds_state, !step_i,
    $stable(fine_q) && $stable(coarse_q) && $stable(sector_q),
    "state moved without an event")

endmodule

@@ hw/rtl/quadrature_hall_position_tracker.sv @@
// ----------------------------------------------------------------------------
// Quadrature/hall position tracker
// Tracks rotor angle in 10/13 degree units from encoder and hall edge events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one edge event per
//   transfer: kind (A edge, B edge, hall edge), edge polarity, the other
//   encoder channel's level and the three hall bits.
//   Output channel (out_valid_o / out_stall_i) returns one result per event:
//   the angle (coarse angle plus fine count) and the stored hall sector.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the encoder
//   counts per hall sector; write it only while no event is in flight.
//   An input transfer passes through the input register, then the single-pass
//   update that loads the result register, before out_valid_o rises.
//   Throughput is one event per cycle while the receiver does not stall,
//   bounded by the single-register state update loop.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more event; in_stall_o rises once both are full.
//   Reset clears the angle state, sets sector 0, arms the first-hall load
//   and sets the counts per sector to 78.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_hall_position_tracker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [qhpt_pkg::KIND_BITS-1:0]          kind_i,
  input  logic                                    rising_i,
  input  logic                                    other_level_i,
  input  logic [qhpt_pkg::HALL_BITS-1:0]          hall_bits_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [qhpt_pkg::OUT_BITS-1:0]    angle_o,
  output logic [qhpt_pkg::SECTOR_BITS-1:0]        sector_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [qhpt_pkg::COUNT_BITS-1:0]         cfg_sector_counts_i
);

  logic                              in_valid_q;
  qhpt_pkg::event_t                  ev_q;
  logic                              out_valid_q;
  qhpt_pkg::result_t                 res_q, res_d;
  logic [qhpt_pkg::COUNT_BITS-1:0]   sector_counts_q;
  logic                              out_free, advance, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_counts_q <= qhpt_pkg::SECTOR_COUNTS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sector_counts_q <= cfg_sector_counts_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (out_free || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_q.kind        <= kind_i;
      ev_q.rising      <= rising_i;
      ev_q.other_level <= other_level_i;
      ev_q.hall_bits   <= hall_bits_i;
    end
  end

  qhpt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .ev_i            (ev_q),
    .sector_counts_i (sector_counts_q),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // The final add of coarse angle and fine count sits after the result register.
  assign out_valid_o = out_valid_q;
  assign angle_o     = res_q.coarse + qhpt_pkg::OUT_BITS'($signed(res_q.fine));
  assign sector_o    = res_q.sector;

  `ASSERT_NEXT(a_advance_gives_result, advance, out_valid_o,
    "event advanced but no result followed")
  `ASSERT_CLK(a_stall_only_when_full, !in_stall_o || (out_valid_o && out_stall_i),
    "input stalled while the result register could take a transfer")
  `ASSERT_CLK(a_empty_never_stalls, in_valid_q || !in_stall_o,
    "input stalled with an empty input register")

endmodule

@@ tb/sv/qhpt_position_checker.sv @@
// ----------------------------------------------------------------------------
// Position tracker checker
// Watches the event, result and configuration channels of the position
// tracker, keeps its own copy of the angle state, predicts one result per
// accepted event and compares every returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qhpt_position_checker
  import qhpt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [KIND_BITS-1:0]          kind_i,
  input  logic                          rising_i,
  input  logic                          other_level_i,
  input  logic [HALL_BITS-1:0]          hall_bits_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [OUT_BITS-1:0]    angle_i,
  input  logic [SECTOR_BITS-1:0]        sector_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [COUNT_BITS-1:0]         cfg_sector_counts_i,
  input  logic                          drain_done_i,
  output int                            pending_o,
  output int                            mismatches_o
);

  localparam logic signed [FINE_BITS-1:0] FINE_TOP = {1'b0, {(FINE_BITS-1){1'b1}}};
  localparam logic signed [FINE_BITS-1:0] FINE_BOTTOM = {1'b1, {(FINE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [OUT_BITS-1:0] angle;
    logic [SECTOR_BITS-1:0]     sector;
  } position_t;

  logic [COUNT_BITS-1:0]       counts_per_sector;
  logic signed [FINE_BITS-1:0] fine_pos;
  logic [ANGLE_BITS-1:0]       coarse_pos;
  logic [SECTOR_BITS-1:0]      last_sector;
  logic                        first_hall_pending;
  position_t                   position_expect_q[$];

  initial mismatches_o = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches_o++;
  endtask

  function automatic logic [ANGLE_BITS-1:0] widen_fine(logic signed [FINE_BITS-1:0] f);
    return {{(ANGLE_BITS-FINE_BITS){f[FINE_BITS-1]}}, f};
  endfunction

  function automatic logic [SECTOR_BITS-1:0] sector_of_code(logic [HALL_BITS-1:0] code);
    case (code)
      3'd5:    return 3'd0;
      3'd4:    return 3'd1;
      3'd6:    return 3'd2;
      3'd2:    return 3'd3;
      3'd3:    return 3'd4;
      3'd1:    return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic void step_fine(logic up);
    if (up) begin
      if (fine_pos != FINE_TOP) fine_pos = fine_pos + 1'b1;
    end else if (fine_pos != FINE_BOTTOM) begin
      fine_pos = fine_pos - 1'b1;
    end
  endfunction

  // Applies one event to the tracked state and returns the position it reports.
  function automatic position_t track_event(logic [KIND_BITS-1:0] k, logic r, logic o,
                                            logic [HALL_BITS-1:0] h);
    position_t              res;
    logic [SECTOR_BITS-1:0] s;
    int                     diff;
    case (k)
      KIND_A: step_fine(r != o);
      KIND_B: step_fine(r == o);
      KIND_HALL: begin
        s = sector_of_code(h);
        if (first_hall_pending) begin
          coarse_pos = widen_fine(fine_pos);
          first_hall_pending = 1'b0;
        end else begin
          diff = int'(s) - int'(last_sector);
          // A jump across the 5/0 boundary is one sector in the short direction.
          if (diff == 5) diff = -1;
          else if (diff == -5) diff = 1;
          coarse_pos = coarse_pos + ANGLE_BITS'(diff * int'(counts_per_sector));
        end
        last_sector = s;
        fine_pos = '0;
      end
      default: ;
    endcase
    res.angle = OUT_BITS'(coarse_pos + widen_fine(fine_pos));
    res.sector = last_sector;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_t want;
    if (!rst_ni) begin
      counts_per_sector = SECTOR_COUNTS_RESET;
      fine_pos = '0;
      coarse_pos = '0;
      last_sector = '0;
      first_hall_pending = 1'b1;
      position_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) counts_per_sector = cfg_sector_counts_i;
      if (out_valid_i && !out_stall_i) begin
        if (position_expect_q.size() == 0) begin
          report_mismatch($sformatf("result angle %0d sector %0d with no event waiting",
                                    angle_i, sector_i));
        end else begin
          want = position_expect_q.pop_front();
          if (angle_i !== want.angle)
            report_mismatch($sformatf("angle %0d, expected %0d", angle_i, want.angle));
          if (sector_i !== want.sector)
            report_mismatch($sformatf("sector %0d, expected %0d", sector_i, want.sector));
        end
      end
      if (in_valid_i && !in_stall_i)
        position_expect_q.push_back(track_event(kind_i, rising_i, other_level_i, hall_bits_i));
      pending_o <= position_expect_q.size();
    end
  end

  always @(posedge drain_done_i) begin
    if (position_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", position_expect_q.size()));
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Position tracker testbench
// Drives directed and randomized encoder and hall edge events into the
// tracker under several sector-count settings, with random stalls on both
// channels, and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import qhpt_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
  localparam int PHASE_EVENTS = 200;
  localparam int HOLD_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid;
  logic                       in_stall;
  logic [KIND_BITS-1:0]       kind;
  logic                       rising;
  logic                       other_level;
  logic [HALL_BITS-1:0]       hall_bits;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_BITS-1:0] angle;
  logic [SECTOR_BITS-1:0]     sector;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [COUNT_BITS-1:0]      cfg_sector_counts;
  logic                       drain_done;
  int                         pending;
  int                         mismatches;

  logic calm;
  int   hold_requests;
  int   holds_served;
  int   enc_pos;
  int   rotor_sector;
  int   to_hall;
  int   events_sent;
  int   hall_sent;
  int   spare_sent;
  int   settings_written;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quadrature_hall_position_tracker dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (kind),
    .rising_i            (rising),
    .other_level_i       (other_level),
    .hall_bits_i         (hall_bits),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .angle_o             (angle),
    .sector_o            (sector),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_sector_counts_i (cfg_sector_counts)
  );

  qhpt_position_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .kind_i              (kind),
    .rising_i            (rising),
    .other_level_i       (other_level),
    .hall_bits_i         (hall_bits),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .angle_i             (angle),
    .sector_i            (sector),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_sector_counts_i (cfg_sector_counts),
    .drain_done_i        (drain_done),
    .pending_o           (pending),
    .mismatches_o        (mismatches)
  );

  function automatic logic [HALL_BITS-1:0] hall_code_of(int s);
    case (s)
      0:       return 3'd5;
      1:       return 3'd4;
      2:       return 3'd6;
      3:       return 3'd2;
      4:       return 3'd3;
      default: return 3'd1;
    endcase
  endfunction

  // Quadrature levels {B, A} for an encoder position; A leads B when counting up.
  function automatic logic [1:0] quad_levels(int p);
    case (p & 3)
      0:       return 2'b00;
      1:       return 2'b01;
      2:       return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  task automatic put_event(logic [KIND_BITS-1:0] k, logic r, logic o, logic [HALL_BITS-1:0] h);
    in_valid <= 1'b1;
    kind <= k;
    rising <= r;
    other_level <= o;
    hall_bits <= h;
    do @(posedge clk); while (in_stall);
    if (k == KIND_SPARE) spare_sent++;
    else events_sent++;
    if (k == KIND_HALL) hall_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_sector_counts(logic [COUNT_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_sector_counts <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // Moves the rotor by whole encoder steps with proper quadrature edges and
  // a hall transition every few steps in the direction of travel.
  task automatic spin(int steps, logic fwd);
    logic [1:0] was;
    logic [1:0] now;
    for (int i = 0; i < steps; i++) begin
      was = quad_levels(enc_pos);
      enc_pos = fwd ? enc_pos + 1 : enc_pos - 1;
      now = quad_levels(enc_pos);
      if (was[0] != now[0]) put_event(KIND_A, now[0], now[1], 3'($urandom));
      else put_event(KIND_B, now[1], now[0], 3'($urandom));
      to_hall--;
      if (to_hall <= 0) begin
        rotor_sector = fwd ? (rotor_sector + 1) % 6 : (rotor_sector + 5) % 6;
        put_event(KIND_HALL, 1'($urandom), 1'($urandom), hall_code_of(rotor_sector));
        to_hall = $urandom_range(2, 24);
      end
    end
  endtask

  // Unstructured events: glitchy edges, sector jumps, invalid hall codes, unused kind.
  task automatic scramble(int n);
    for (int i = 0; i < n; i++)
      put_event(2'($urandom), 1'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic random_motion(int n);
    int target;
    target = events_sent + n;
    while (events_sent < target) begin
      if ($urandom_range(0, 4) == 0) scramble($urandom_range(3, 12));
      else spin($urandom_range(4, 40), 1'($urandom));
    end
  endtask

  task automatic run_directed();
    // Every direction rule of both channels, hall bits ignored on encoder edges.
    put_event(KIND_A, 1'b1, 1'b0, 3'd7);
    put_event(KIND_A, 1'b0, 1'b0, 3'd0);
    put_event(KIND_A, 1'b1, 1'b1, 3'd7);
    put_event(KIND_A, 1'b0, 1'b1, 3'd0);
    put_event(KIND_B, 1'b1, 1'b1, 3'd7);
    put_event(KIND_B, 1'b0, 1'b0, 3'd7);
    put_event(KIND_B, 1'b1, 1'b0, 3'd0);
    put_event(KIND_B, 1'b0, 1'b1, 3'd0);
    put_event(KIND_B, 1'b1, 1'b1, 3'd5);
    put_event(KIND_SPARE, 1'b1, 1'b1, 3'd7);
    // The first hall edge loads the coarse angle from the fine count.
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd3);
    put_event(KIND_HALL, 1'b1, 1'b0, 3'd1);
    // Crossing from sector 5 to 0 and back counts one sector, not five.
    put_event(KIND_HALL, 1'b0, 1'b1, 3'd5);
    put_event(KIND_HALL, 1'b1, 1'b1, 3'd1);
    // Both invalid codes fall on sector 0.
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd0);
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd7);
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd3);
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd4);
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd2);
    put_event(KIND_HALL, 1'b1, 1'b1, 3'd6);
    put_event(KIND_A, 1'b1, 1'b0, 3'd0);
    put_event(KIND_B, 1'b1, 1'b1, 3'd2);
    put_event(KIND_SPARE, 1'b0, 1'b0, 3'd0);
    put_event(KIND_HALL, 1'b0, 1'b0, 3'd5);
  endtask

  // Receiver: random stall bursts, plus a long hold-off whenever one is requested.
  initial begin
    out_stall <= 1'b0;
    holds_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run did not finish in time; %0d results outstanding.", pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_valid <= 1'b0;
    kind <= KIND_A;
    rising <= 1'b0;
    other_level <= 1'b0;
    hall_bits <= '0;
    cfg_valid <= 1'b0;
    cfg_sector_counts <= SECTOR_COUNTS_RESET;
    drain_done <= 1'b0;
    calm <= 1'b0;
    hold_requests = 0;
    enc_pos = 0;
    rotor_sector = 0;
    to_hall = 8;
    events_sent = 0;
    hall_sent = 0;
    spare_sent = 0;
    settings_written = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: write_sector_counts(10'd1023);
        1: write_sector_counts(10'd1);
        2: write_sector_counts(10'd0);
        3: write_sector_counts(10'($urandom_range(2, 1022)));
        default: write_sector_counts(SECTOR_COUNTS_RESET);
      endcase
      case (ph)
        1: begin
          // Walk the fine count a long way up and then further down without
          // any hall edge, then let one hall edge clear it.
          calm <= 1'b1;
          to_hall = 1 << 20;
          spin(60, 1'b1);
          spin(120, 1'b0);
          to_hall = 1;
          spin(1, 1'b1);
          calm <= 1'b0;
          random_motion(PHASE_EVENTS);
        end
        2: begin
          // The receiver holds off while events keep coming, so the block fills.
          calm <= 1'b1;
          hold_requests++;
          spin(40, 1'b1);
          calm <= 1'b0;
          random_motion(PHASE_EVENTS / 2);
          wait_drained();
          random_motion(PHASE_EVENTS / 2);
        end
        4: begin
          random_motion(PHASE_EVENTS / 2);
          calm <= 1'b1;
          random_motion(PHASE_EVENTS / 2);
        end
        default: random_motion(PHASE_EVENTS);
      endcase
    end

    wait_drained();
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d tracking events (%0d hall edges) and %0d unused-kind events",
             events_sent, hall_sent, spare_sent);
    $display("over %0d sector-count settings, with long hall-free walks of the fine count.",
             settings_written + 1);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ quadrature_hall_position_tracker.f @@
+incdir+hw/rtl
hw/rtl/qhpt_pkg.sv
hw/rtl/qhpt_core.sv
hw/rtl/quadrature_hall_position_tracker.sv
tb/sv/qhpt_position_checker.sv
tb/sv/tb.sv
